// ===== design/wwvb_tcd_pkg.sv =====
package wwvb_tcd_pkg;

  localparam int unsigned LenW      = 12;
  localparam int unsigned PosW      = 6;
  localparam int unsigned WeightW   = 8;
  localparam int unsigned DayW      = 9;
  localparam logic [5:0]  LastPos   = 6'd59;

  typedef enum logic [1:0] {
    SYM_ZERO   = 2'd0,
    SYM_ONE    = 2'd1,
    SYM_MARKER = 2'd2,
    SYM_ERROR  = 2'd3
  } sym_e;

  typedef enum logic [1:0] {
    REG_ERROR_LIMIT  = 2'd0,
    REG_MARKER_LIMIT = 2'd1,
    REG_ONE_LIMIT    = 2'd2,
    REG_ZERO_LIMIT   = 2'd3
  } reg_idx_e;

  typedef enum logic [3:0] {
    SLOT_UNUSED   = 4'd0,
    SLOT_MINUTE   = 4'd1,
    SLOT_HOUR     = 4'd2,
    SLOT_DAY      = 4'd3,
    SLOT_YEAR     = 4'd4,
    SLOT_LEAP_YR  = 4'd5,
    SLOT_LEAP_SEC = 4'd6,
    SLOT_DST      = 4'd7,
    SLOT_MARKER   = 4'd8
  } slot_kind_e;

  typedef struct packed {
    logic [1:0] symbol;
    logic [5:0] position;
    logic       frame_done;
    logic       frame_error;
    logic [6:0] minutes;
    logic [5:0] hours;
    logic [8:0] day_of_year;
    logic [7:0] year_of_century;
    logic [3:0] month;
    logic [4:0] day_of_month;
    logic [1:0] leap_flags;
    logic [1:0] dst_state;
  } result_t;

  function automatic slot_kind_e slot_kind(input logic [5:0] pos);
    slot_kind_e k;
    case (pos)
      6'd0, 6'd9, 6'd19, 6'd29, 6'd39, 6'd49, 6'd59: k = SLOT_MARKER;
      6'd1, 6'd2, 6'd3, 6'd5, 6'd6, 6'd7, 6'd8: k = SLOT_MINUTE;
      6'd12, 6'd13, 6'd15, 6'd16, 6'd17, 6'd18: k = SLOT_HOUR;
      6'd22, 6'd23, 6'd25, 6'd26, 6'd27, 6'd28,
      6'd30, 6'd31, 6'd32, 6'd33: k = SLOT_DAY;
      6'd45, 6'd46, 6'd47, 6'd48, 6'd50, 6'd51, 6'd52, 6'd53: k = SLOT_YEAR;
      6'd55: k = SLOT_LEAP_YR;
      6'd56: k = SLOT_LEAP_SEC;
      6'd57, 6'd58: k = SLOT_DST;
      default: k = SLOT_UNUSED;
    endcase
    return k;
  endfunction

  function automatic logic [WeightW-1:0] slot_weight(input logic [5:0] pos);
    logic [WeightW-1:0] w;
    case (pos)
      6'd22: w = 8'd200;
      6'd23: w = 8'd100;
      6'd25, 6'd45: w = 8'd80;
      6'd1, 6'd26, 6'd46: w = 8'd40;
      6'd2, 6'd12, 6'd27, 6'd47: w = 8'd20;
      6'd3, 6'd13, 6'd28, 6'd48: w = 8'd10;
      6'd5, 6'd15, 6'd30, 6'd50: w = 8'd8;
      6'd6, 6'd16, 6'd31, 6'd51: w = 8'd4;
      6'd7, 6'd17, 6'd32, 6'd52, 6'd57: w = 8'd2;
      6'd8, 6'd18, 6'd33, 6'd53, 6'd55, 6'd56, 6'd58: w = 8'd1;
      default: w = 8'd0;
    endcase
    return w;
  endfunction

  function automatic logic [DayW-1:0] days_before(input logic [3:0] m);
    logic [DayW-1:0] d;
    case (m)
      4'd0:  d = 9'd0;
      4'd1:  d = 9'd31;
      4'd2:  d = 9'd59;
      4'd3:  d = 9'd90;
      4'd4:  d = 9'd120;
      4'd5:  d = 9'd151;
      4'd6:  d = 9'd181;
      4'd7:  d = 9'd212;
      4'd8:  d = 9'd243;
      4'd9:  d = 9'd273;
      4'd10: d = 9'd304;
      4'd11: d = 9'd334;
      4'd12: d = 9'd365;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

endpackage

// ===== design/wwvb_tcd_if.sv =====
interface wwvb_tcd_pulse_if;
  logic        valid;
  logic        ready;
  logic [11:0] pulse_length;

  modport source (output valid, output pulse_length, input ready);
  modport sink (input valid, input pulse_length, output ready);
endinterface

interface wwvb_tcd_result_if;
  logic       valid;
  logic       ready;
  logic [1:0] symbol;
  logic [5:0] position;
  logic       frame_done;
  logic       frame_error;
  logic [6:0] minutes;
  logic [5:0] hours;
  logic [8:0] day_of_year;
  logic [7:0] year_of_century;
  logic [3:0] month;
  logic [4:0] day_of_month;
  logic [1:0] leap_flags;
  logic [1:0] dst_state;

  modport source (
    output valid, output symbol, output position, output frame_done, output frame_error,
    output minutes, output hours, output day_of_year, output year_of_century,
    output month, output day_of_month, output leap_flags, output dst_state,
    input ready
  );
  modport sink (
    input valid, input symbol, input position, input frame_done, input frame_error,
    input minutes, input hours, input day_of_year, input year_of_century,
    input month, input day_of_month, input leap_flags, input dst_state,
    output ready
  );
endinterface

// ===== design/wwvb_tcd_classify.sv =====
module wwvb_tcd_classify import wwvb_tcd_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic [1:0]      cfg_index_i,
  input  logic [LenW-1:0] cfg_wdata_i,
  input  logic [LenW-1:0] len_i,
  output sym_e            sym_o
);

  logic [LenW-1:0] error_limit_q, marker_limit_q, one_limit_q, zero_limit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      error_limit_q  <= 12'd100;
      marker_limit_q <= 12'd400;
      one_limit_q    <= 12'd700;
      zero_limit_q   <= 12'd1000;
    end else if (cfg_we_i) begin
      case (reg_idx_e'(cfg_index_i))
        REG_ERROR_LIMIT:  error_limit_q  <= cfg_wdata_i;
        REG_MARKER_LIMIT: marker_limit_q <= cfg_wdata_i;
        REG_ONE_LIMIT:    one_limit_q    <= cfg_wdata_i;
        REG_ZERO_LIMIT:   zero_limit_q   <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (len_i < error_limit_q) begin
      sym_o = SYM_ERROR;
    end else if (len_i < marker_limit_q) begin
      sym_o = SYM_MARKER;
    end else if (len_i < one_limit_q) begin
      sym_o = SYM_ONE;
    end else if (len_i < zero_limit_q) begin
      sym_o = SYM_ZERO;
    end else begin
      sym_o = SYM_ERROR;
    end
  end

endmodule

// ===== design/wwvb_tcd_calendar.sv =====
module wwvb_tcd_calendar import wwvb_tcd_pkg::*; (
  input  logic [DayW-1:0] day_i,
  input  logic            leap_i,
  output logic [3:0]      month_o,
  output logic [4:0]      dom_o
);

  logic [DayW-1:0] start_k;
  logic [DayW-1:0] prev_start;
  logic [DayW-1:0] dom_full;
  logic [3:0]      m;

  always_comb begin
    m = 4'd12;
    start_k = '0;
    for (int k = 12; k >= 1; k--) begin
      start_k = days_before(4'(k)) + ((k >= 2) ? {{(DayW-1){1'b0}}, leap_i} : '0);
      if (day_i <= start_k) begin
        m = 4'(k);
      end
    end
    prev_start = days_before(m - 4'd1)
                 + ((m >= 4'd3) ? {{(DayW-1){1'b0}}, leap_i} : '0);
    dom_full = day_i - prev_start;
    if (day_i == '0) begin
      month_o = 4'd1;
      dom_o   = 5'd1;
    end else begin
      month_o = m;
      dom_o   = (dom_full > 9'd31) ? 5'd31 : dom_full[4:0];
    end
  end

endmodule

// ===== design/wwvb_tcd_frame.sv =====
module wwvb_tcd_frame import wwvb_tcd_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    step_i,
  input  sym_e    sym_i,
  output result_t res_o
);

  logic [PosW-1:0] fpos_q, fpos_d;
  logic            in_sync_q, in_sync_d;
  logic            last_q, last_d;
  logic            err_q, err_d;
  logic [6:0]      min_q, min_d;
  logic [5:0]      hour_q, hour_d;
  logic [8:0]      day_q, day_d;
  logic [7:0]      year_q, year_d;
  logic            leap_yr_q, leap_yr_d;
  logic            leap_sec_q, leap_sec_d;
  logic [1:0]      dst_q, dst_d;

  logic               marker;
  logic               clear;
  logic               slip;
  logic               done;
  logic [PosW-1:0]    p;
  logic [PosW-1:0]    pos;
  slot_kind_e         kind;
  logic [WeightW-1:0] w;
  logic [3:0]         cal_month;
  logic [4:0]         cal_dom;

  wwvb_tcd_calendar u_calendar (
    .day_i   (day_q),
    .leap_i  (leap_yr_q),
    .month_o (cal_month),
    .dom_o   (cal_dom)
  );

  always_comb begin
    fpos_d     = fpos_q;
    in_sync_d  = in_sync_q;
    err_d      = err_q;
    min_d      = min_q;
    hour_d     = hour_q;
    day_d      = day_q;
    year_d     = year_q;
    leap_yr_d  = leap_yr_q;
    leap_sec_d = leap_sec_q;
    dst_d      = dst_q;
    marker     = (sym_i == SYM_MARKER);
    last_d     = marker;
    clear      = 1'b0;
    slip       = 1'b0;
    done       = 1'b0;
    pos        = '0;
    p          = '0;
    kind       = SLOT_UNUSED;
    w          = '0;

    if (!in_sync_q) begin
      if (marker && last_q) begin
        in_sync_d = 1'b1;
        clear     = 1'b1;
        fpos_d    = 6'd1;
      end
    end else begin
      p = (fpos_q > LastPos) ? '0 : fpos_q;
      if (marker && last_q && (p != '0)) begin
        clear  = 1'b1;
        slip   = 1'b1;
        fpos_d = 6'd1;
      end else begin
        pos  = p;
        kind = slot_kind(p);
        w    = slot_weight(p);
        if ((sym_i == SYM_ERROR) || ((kind == SLOT_MARKER) != marker)) begin
          err_d = 1'b1;
        end
        if (sym_i == SYM_ONE) begin
          case (kind)
            SLOT_MINUTE:   min_d      = 7'(min_q + w[6:0]);
            SLOT_HOUR:     hour_d     = 6'(hour_q + w[5:0]);
            SLOT_DAY:      day_d      = 9'(day_q + {1'b0, w});
            SLOT_YEAR:     year_d     = 8'(year_q + w);
            SLOT_LEAP_YR:  leap_yr_d  = 1'b1;
            SLOT_LEAP_SEC: leap_sec_d = 1'b1;
            SLOT_DST:      dst_d      = dst_q | w[1:0];
            default: ;
          endcase
        end
        if (p == LastPos) begin
          done   = 1'b1;
          clear  = 1'b1;
          fpos_d = '0;
        end else begin
          fpos_d = p + 6'd1;
        end
      end
    end

    res_o          = '0;
    res_o.symbol   = sym_i;
    res_o.position = pos;
    if (done) begin
      res_o.frame_done      = 1'b1;
      res_o.frame_error     = err_d;
      res_o.minutes         = min_d;
      res_o.hours           = hour_d;
      res_o.day_of_year     = day_d;
      res_o.year_of_century = year_d;
      res_o.month           = cal_month;
      res_o.day_of_month    = cal_dom;
      res_o.leap_flags      = {leap_sec_d, leap_yr_d};
      res_o.dst_state       = dst_d;
    end

    if (clear) begin
      min_d      = '0;
      hour_d     = '0;
      day_d      = '0;
      year_d     = '0;
      leap_yr_d  = 1'b0;
      leap_sec_d = 1'b0;
      dst_d      = '0;
      err_d      = slip;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fpos_q     <= '0;
      in_sync_q  <= 1'b0;
      last_q     <= 1'b0;
      err_q      <= 1'b0;
      min_q      <= '0;
      hour_q     <= '0;
      day_q      <= '0;
      year_q     <= '0;
      leap_yr_q  <= 1'b0;
      leap_sec_q <= 1'b0;
      dst_q      <= '0;
    end else if (step_i) begin
      fpos_q     <= fpos_d;
      in_sync_q  <= in_sync_d;
      last_q     <= last_d;
      err_q      <= err_d;
      min_q      <= min_d;
      hour_q     <= hour_d;
      day_q      <= day_d;
      year_q     <= year_d;
      leap_yr_q  <= leap_yr_d;
      leap_sec_q <= leap_sec_d;
      dst_q      <= dst_d;
    end
  end

endmodule

// ===== design/wwvb_time_code_decoder.sv =====
// Channel    Modport   Carries
// pulse_i    sink      pulse_length (12 bits, ms)
// result_o   source    symbol, position, frame fields of one decoded second
// cfg_*_i    write     four 12-bit pulse length limits, no read-back
//
// Every pulse yields one result transaction, via the input and result registers.
// A new pulse can be taken every cycle: the input register and the result register
// each advance whenever the stage after them is free.
// Reset clears the frame state and loads the default limits.
// A stalled result holds its register; the input register still takes one more pulse if it is empty.
module wwvb_time_code_decoder import wwvb_tcd_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [1:0]               cfg_index_i,
  input  logic [LenW-1:0]          cfg_wdata_i,
  wwvb_tcd_pulse_if.sink           pulse_i,
  wwvb_tcd_result_if.source        result_o
);

  logic            in_valid_q;
  logic [LenW-1:0] len_q;
  logic            out_valid_q;
  result_t         res_q;
  result_t         res;
  sym_e            sym;
  logic            out_load;
  logic            in_load;
  logic            step;

  assign out_load      = !out_valid_q || result_o.ready;
  assign in_load       = !in_valid_q || out_load;
  assign step          = in_valid_q && out_load;
  assign pulse_i.ready = in_load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_load) begin
        in_valid_q <= pulse_i.valid;
      end
      if (out_load) begin
        out_valid_q <= in_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_load && pulse_i.valid) begin
      len_q <= pulse_i.pulse_length;
    end
    if (step) begin
      res_q <= res;
    end
  end

  wwvb_tcd_classify u_classify (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .len_i       (len_q),
    .sym_o       (sym)
  );

  wwvb_tcd_frame u_frame (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .sym_i  (sym),
    .res_o  (res)
  );

  assign result_o.valid           = out_valid_q;
  assign result_o.symbol          = res_q.symbol;
  assign result_o.position        = res_q.position;
  assign result_o.frame_done      = res_q.frame_done;
  assign result_o.frame_error     = res_q.frame_error;
  assign result_o.minutes         = res_q.minutes;
  assign result_o.hours           = res_q.hours;
  assign result_o.day_of_year     = res_q.day_of_year;
  assign result_o.year_of_century = res_q.year_of_century;
  assign result_o.month           = res_q.month;
  assign result_o.day_of_month    = res_q.day_of_month;
  assign result_o.leap_flags      = res_q.leap_flags;
  assign result_o.dst_state       = res_q.dst_state;

  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (res_q.position <= LastPos))
    else $error("result position beyond the end of the frame");

  a_done_at_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && res_q.frame_done) |-> (res_q.position == LastPos))
    else $error("frame completed away from the last second");

  a_month_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && res_q.frame_done) |-> (res_q.month >= 4'd1 && res_q.month <= 4'd12))
    else $error("decoded month out of range");

  a_no_frame_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !res_q.frame_done) |-> (res_q.month == '0 && !res_q.frame_error))
    else $error("frame fields set without a completed frame");

endmodule
